@@ hdl/stq_pkg.sv @@
// Shared types and constants for the sorted sleep timer queue.
package stq_pkg;

   // field widths
   localparam int ID_W   = 16;
   localparam int SECS_W = 16;
   localparam int NOW_W  = 32;
   localparam int UPS_W  = 24;
   localparam int PROD_W = SECS_W + UPS_W;
   localparam int WAKE_W = 42;
   localparam int KIND_W = 2;

   // queue sizing
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int MAX_WOKEN       = 16;
   localparam int WOKE_W          = $clog2(MAX_WOKEN + 1);

   // register reset
   localparam logic [UPS_W-1:0] UPS_RESET = 24'd1000000;

   // op codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WOKEN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

   // add status
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef logic [WAKE_W-1:0] wake_type;

   // one queue slot
   typedef struct packed {
      wake_type        wake;
      logic [ID_W-1:0] id;
   } entry_type;

endpackage

@@ hdl/stq_mem.sv @@
// Queue storage: one write port and one registered read port.
module stq_mem #(
   parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
   input  stq_pkg::entry_type             wr_entry,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
   output stq_pkg::entry_type             rd_entry
);
   import stq_pkg::*;

   entry_type mem_ff [QUEUE_DEPTH];
   entry_type rd_entry_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem_ff[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

@@ hdl/stq_cmp.sv @@
// Shared wake time comparator, used by both insert scan and tick scan.
module stq_cmp (
   input  stq_pkg::wake_type lhs,
   input  stq_pkg::wake_type rhs,
   output logic              gt
);
   import stq_pkg::*;

   assign gt = (lhs > rhs);

endmodule

@@ hdl/sleep_timer_queue_unit.sv @@
// Top level of the sorted sleep timer queue: sequencer, multiply-add and result port.
//
// Sleepers are held in a circular buffer in a single-port-read RAM, sorted by wake
// time with the head the earliest. An add computes wake = seconds * units_per_second
// + now (42 bits, no overflow) in S_MUL and S_SUM, then walks from the tail toward
// the head, reading each entry in S_ARD and comparing it in S_ACMP, moving each
// entry with an equal or later wake time one slot back, and writes the new entry in
// the gap. A full queue answers at once. A tick reads the head through the one read
// port and the shared comparator in S_TRD and S_TCMP and pops each due entry, at most
// MAX_WOKEN per tick. busy is high for the whole sequence. Results come one per cycle
// at most on rsp_strobe and cannot be held off; a tick gives its woken ids head first,
// last marked. Write csr_write_enable only when idle.
module sleep_timer_queue_unit #(
   parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_op,
   input  logic [stq_pkg::ID_W-1:0]    req_requester_id,
   input  logic [stq_pkg::SECS_W-1:0]  req_sleep_seconds,
   input  logic [stq_pkg::NOW_W-1:0]   req_now,
   output logic                        rsp_strobe,
   output logic [stq_pkg::KIND_W-1:0]  rsp_kind,
   output logic                        rsp_status,
   output logic [stq_pkg::ID_W-1:0]    rsp_woken_id,
   output logic                        rsp_last,
   input  logic                        csr_write_enable,
   input  logic [stq_pkg::UPS_W-1:0]   csr_write_data
);
   import stq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int PTR_W = IDX_W + 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MUL  = 7'b0000010,
      S_SUM  = 7'b0000100,
      S_ARD  = 7'b0001000,
      S_ACMP = 7'b0010000,
      S_TRD  = 7'b0100000,
      S_TCMP = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [UPS_W-1:0]   ups_ff, ups_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [WOKE_W-1:0]  woke_ff, woke_in;
   logic               pend_ff, pend_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   logic               op_ff, op_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [SECS_W-1:0]  secs_ff, secs_in;
   logic [NOW_W-1:0]   now_ff, now_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   wake_type           wake_ff, wake_in;
   logic [ID_W-1:0]    pend_id_ff, pend_id_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   entry_type          mem_wr_entry;
   logic [IDX_W-1:0]   mem_rd_addr;
   entry_type          mem_rd_entry;
   entry_type          new_entry;

   wake_type           cmp_lhs, cmp_rhs;
   logic               cmp_gt;
   logic               due;
   logic [PTR_W-1:0]   pos_sum, prev_sum;

   // fold a head-relative sum back into the buffer (sum stays below twice the depth)
   function automatic logic [IDX_W-1:0] wrap_idx(input logic [PTR_W-1:0] sum);
      logic [PTR_W-1:0] folded;
      folded = (sum >= PTR_W'(QUEUE_DEPTH)) ? (sum - PTR_W'(QUEUE_DEPTH)) : sum;
      return folded[IDX_W-1:0];
   endfunction

   // queue storage
   stq_mem #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_mem (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_entry (mem_wr_entry),
      .rd_addr  (mem_rd_addr),
      .rd_entry (mem_rd_entry)
   );

   // shared comparator: add asks new > slot, tick asks slot > now
   always_comb begin
      if (op_ff == OP_TICK) begin
         cmp_lhs = mem_rd_entry.wake;
         cmp_rhs = WAKE_W'(now_ff);
      end else begin
         cmp_lhs = wake_ff;
         cmp_rhs = mem_rd_entry.wake;
      end
   end

   stq_cmp u_cmp (
      .lhs (cmp_lhs),
      .rhs (cmp_rhs),
      .gt  (cmp_gt)
   );

   // addresses relative to the head
   assign pos_sum   = PTR_W'(head_ff) + PTR_W'(idx_ff);
   assign prev_sum  = pos_sum - PTR_W'(1);
   assign new_entry = '{wake: wake_ff, id: id_ff};

   // head entry is due to wake
   assign due = (count_ff != '0) && (woke_ff < WOKE_W'(MAX_WOKEN)) && !cmp_gt;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ups_in        = ups_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      woke_in       = woke_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      op_in         = op_ff;
      id_in         = id_ff;
      secs_in       = secs_ff;
      now_in        = now_ff;
      prod_in       = prod_ff;
      wake_in       = wake_ff;
      pend_id_in    = pend_id_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = wrap_idx(pos_sum);
      mem_wr_entry  = new_entry;
      mem_rd_addr   = (op_ff == OP_TICK) ? head_ff : wrap_idx(prev_sum);

      if (csr_write_enable) begin
         ups_in = csr_write_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in   = req_op;
               id_in   = req_requester_id;
               secs_in = req_sleep_seconds;
               now_in  = req_now;
               woke_in = '0;
               pend_in = 1'b0;
               if (req_op == OP_ADD) begin
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = KIND_ADD;
                     rsp_status_in = STATUS_FULL;
                     rsp_id_in     = '0;
                     rsp_last_in   = 1'b1;
                  end else begin
                     state_in = S_MUL;
                  end
               end else begin
                  state_in = S_TRD;
               end
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(secs_ff) * PROD_W'(ups_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            wake_in  = WAKE_W'(prod_ff) + WAKE_W'(now_ff);
            idx_in   = count_ff;
            state_in = S_ARD;
         end
         S_ARD: begin
            // at the head: the new entry goes in the head slot
            if (idx_ff == '0) begin
               mem_wr_en     = 1'b1;
               count_in      = count_ff + CNT_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_ADD;
               rsp_status_in = STATUS_OK;
               rsp_id_in     = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_ACMP;
            end
         end
         S_ACMP: begin
            mem_wr_en = 1'b1;
            if (cmp_gt) begin
               // new wake strictly later than the slot ahead: insert here
               count_in      = count_ff + CNT_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_ADD;
               rsp_status_in = STATUS_OK;
               rsp_id_in     = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               // move the slot ahead one place back
               mem_wr_entry = mem_rd_entry;
               idx_in       = idx_ff - CNT_W'(1);
               state_in     = S_ARD;
            end
         end
         S_TRD: begin
            state_in = S_TCMP;
         end
         S_TCMP: begin
            // the held id goes out once we know whether another follows
            if (pend_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_WOKEN;
               rsp_status_in = STATUS_OK;
               rsp_id_in     = pend_id_ff;
               rsp_last_in   = !due;
            end else if (!due) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_NONE;
               rsp_status_in = STATUS_OK;
               rsp_id_in     = '0;
               rsp_last_in   = 1'b1;
            end
            if (due) begin
               pend_in    = 1'b1;
               pend_id_in = mem_rd_entry.id;
               head_in    = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
               count_in   = count_ff - CNT_W'(1);
               woke_in    = woke_ff + WOKE_W'(1);
               state_in   = S_TRD;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ups_ff        <= UPS_RESET;
         head_ff       <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         woke_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ups_ff        <= ups_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         woke_ff       <= woke_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      secs_ff       <= secs_in;
      now_ff        <= now_in;
      prod_ff       <= prod_in;
      wake_ff       <= wake_in;
      pend_id_ff    <= pend_id_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_woken_id = rsp_id_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef ASSERT_OFF
   // occupancy never passes the buffer size
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   // only woken results may leave last low
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_kind != KIND_WOKEN)) |-> rsp_last)
      else $error("non-woken result without last");

   // an add into a full queue answers full on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_ADD) && (count_ff == CNT_W'(QUEUE_DEPTH)))
      |=> (rsp_strobe && (rsp_kind == KIND_ADD) && (rsp_status == STATUS_FULL)))
      else $error("full add not answered");

   // each pop during a tick removes exactly one entry
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_TCMP) && due) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("tick pop count mismatch");
`endif

endmodule

@@ dv/sleep_timer_queue_unit_tb.sv @@
// Testbench for the sorted sleep timer queue: directed and random items against a predictor.
`timescale 1ns / 100ps

module sleep_timer_queue_unit_tb;
   import stq_pkg::*;

   localparam int DEPTH        = QUEUE_DEPTH_DEF;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
   localparam int PHASE_ITEMS  = 42;
   localparam int FAR_LIMIT    = 3;
   localparam wake_type NOW_MAX = wake_type'({NOW_W{1'b1}});

   // one expected result item
   typedef struct {
      logic [KIND_W-1:0] kind;
      logic              status;
      logic [ID_W-1:0]   woken_id;
      logic              last;
   } sleep_result_type;

   // Tracks the sleeper queue and the results still owed by the block
   class sleeper_tracker_type;
      logic [UPS_W-1:0] rate;
      wake_type         wake_times[$];
      logic [ID_W-1:0]  sleeper_ids[$];
      sleep_result_type due_results[$];
      int               mismatches;

      function new();
         rate = UPS_RESET;
         mismatches = 0;
      endfunction

      // entries whose wake time no 32-bit tick can reach
      function int far_count();
         int n;
         n = 0;
         foreach (wake_times[i])
            if (wake_times[i] > NOW_MAX) n++;
         return n;
      endfunction

      function void push_result(logic [KIND_W-1:0] kind, logic status,
                                logic [ID_W-1:0] woken_id, logic last);
         sleep_result_type r;
         r.kind = kind;
         r.status = status;
         r.woken_id = woken_id;
         r.last = last;
         due_results.push_back(r);
      endfunction

      // Work out the results of one accepted item and update the queue
      function void note_item(logic op, logic [ID_W-1:0] rid, logic [SECS_W-1:0] secs,
                              logic [NOW_W-1:0] t_now);
         wake_type wake;
         int       pos;
         int       woken;
         int       i;
         if (op == OP_ADD) begin
            if (wake_times.size() >= DEPTH) begin
               push_result(KIND_ADD, STATUS_FULL, '0, 1'b1);
               return;
            end
            wake = wake_type'(secs) * wake_type'(rate) + wake_type'(t_now);
            // new entry goes ahead of any equal wake time
            pos = 0;
            while (pos < wake_times.size() && wake > wake_times[pos]) pos++;
            wake_times.insert(pos, wake);
            sleeper_ids.insert(pos, rid);
            push_result(KIND_ADD, STATUS_OK, '0, 1'b1);
         end else begin
            woken = 0;
            while (woken < wake_times.size() && woken < MAX_WOKEN &&
                   wake_times[woken] <= wake_type'(t_now))
               woken++;
            if (woken == 0) push_result(KIND_NONE, STATUS_OK, '0, 1'b1);
            for (i = 0; i < woken; i++) begin
               push_result(KIND_WOKEN, STATUS_OK, sleeper_ids.pop_front(), i == woken - 1);
               void'(wake_times.pop_front());
            end
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
         end
      endfunction

      // Compare one result from the block with the oldest expectation
      function void check_result(logic [KIND_W-1:0] kind, logic status,
                                 logic [ID_W-1:0] woken_id, logic last);
         sleep_result_type r;
         if (due_results.size() == 0) begin
            $error("unexpected result: kind %0h, woken_id %0h", kind, woken_id);
            mismatches++;
            return;
         end
         r = due_results.pop_front();
         compare_field("kind", 32'(r.kind), 32'(kind));
         compare_field("status", 32'(r.status), 32'(status));
         compare_field("woken_id", 32'(r.woken_id), 32'(woken_id));
         compare_field("last", 32'(r.last), 32'(last));
      endfunction
   endclass

   logic                clock;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic                req_op           = OP_ADD;
   logic [ID_W-1:0]     req_requester_id = '0;
   logic [SECS_W-1:0]   req_sleep_seconds = '0;
   logic [NOW_W-1:0]    req_now          = '0;
   logic                rsp_strobe;
   logic [KIND_W-1:0]   rsp_kind;
   logic                rsp_status;
   logic [ID_W-1:0]     rsp_woken_id;
   logic                rsp_last;
   logic                csr_write_enable = 1'b0;
   logic [UPS_W-1:0]    csr_write_data   = '0;

   sleeper_tracker_type sb;
   int                  stall_count = 0;

   sleep_timer_queue_unit #(
      .QUEUE_DEPTH(DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_requester_id (req_requester_id),
      .req_sleep_seconds(req_sleep_seconds),
      .req_now          (req_now),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_status       (rsp_status),
      .rsp_woken_id     (rsp_woken_id),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result checks and stall watchdog
   always @(posedge clock) begin
      if (reset) begin
         stall_count = 0;
      end else begin
         if (rsp_strobe === 1'b1) sb.check_result(rsp_kind, rsp_status, rsp_woken_id, rsp_last);
         if (rsp_strobe === 1'b1 || (start && !busy)) stall_count = 0;
         else stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Present one item and hold it until the block takes it
   task send_item(logic op, logic [ID_W-1:0] rid, logic [SECS_W-1:0] secs,
                  logic [NOW_W-1:0] t_now);
      start             <= 1'b1;
      req_op            <= op;
      req_requester_id  <= rid;
      req_sleep_seconds <= secs;
      req_now           <= t_now;
      do @(posedge clock); while (busy);
      sb.note_item(op, rid, secs, t_now);
   endtask

   task idle_gap(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Wait until every owed result is in and the block is idle
   task wait_quiet();
      start <= 1'b0;
      while (sb.due_results.size() != 0 || busy) @(posedge clock);
   endtask

   task write_rate(logic [UPS_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.rate = value;
   endtask

   // Add a sleeper: mostly reachable wake times, some equal to a queued one
   task add_random();
      logic [SECS_W-1:0] secs;
      logic [NOW_W-1:0]  t_now;
      wake_type          target;
      longint unsigned   lim;
      int                pick;
      pick = $urandom_range(0, 9);
      target = NOW_MAX + 1;
      if (pick <= 3 && sb.wake_times.size() > 0)
         target = sb.wake_times[$urandom_range(0, sb.wake_times.size() - 1)];
      if (pick == 0 && sb.far_count() < FAR_LIMIT) begin
         secs  = SECS_W'($urandom);
         t_now = $urandom;
      end else if (target <= NOW_MAX) begin
         // land exactly on an existing wake time
         if (sb.rate == 0) begin
            secs  = SECS_W'($urandom);
            t_now = target[NOW_W-1:0];
         end else if ($urandom_range(0, 1) == 1) begin
            lim = longint'(target) / sb.rate;
            if (lim > 65535) lim = 65535;
            secs  = SECS_W'(lim);
            t_now = NOW_W'(target - wake_type'(secs) * wake_type'(sb.rate));
         end else begin
            secs  = '0;
            t_now = target[NOW_W-1:0];
         end
      end else begin
         t_now = $urandom;
         if ($urandom_range(0, 3) == 0) t_now = t_now >> $urandom_range(1, 31);
         if (sb.rate == 0) lim = 65535;
         else lim = (64'hFFFF_FFFF - longint'(t_now)) / sb.rate;
         if (lim > 65535) lim = 65535;
         secs = SECS_W'($urandom_range(0, 32'(lim)));
      end
      send_item(OP_ADD, ID_W'($urandom), secs, t_now);
   endtask

   // Tick near a queued wake time, or at the ends of the time range
   task tick_random();
      logic [NOW_W-1:0] t_now;
      int               pick;
      int               reach;
      pick = $urandom_range(0, 9);
      reach = sb.wake_times.size() - sb.far_count();
      if (pick < 5 && reach > 0) begin
         t_now = sb.wake_times[$urandom_range(0, reach - 1)][NOW_W-1:0];
         if ($urandom_range(0, 2) == 0 && t_now != 0) t_now = t_now - 1;
      end else if (pick == 5) begin
         t_now = '1;
      end else if (pick == 6) begin
         t_now = '0;
      end else begin
         t_now = $urandom;
      end
      send_item(OP_TICK, ID_W'($urandom), SECS_W'($urandom), t_now);
   endtask

   initial begin
      logic [UPS_W-1:0] rates[6];
      int               phase;
      int               sent;
      int               burst;
      int               add_pct;
      int               i;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty tick, equal wake times, unreachable entry, fill to full
      send_item(OP_TICK, 16'h0000, 16'h0000, 32'h0000_0000);
      send_item(OP_ADD, 16'h0000, 16'h0000, 32'h0000_0000);
      send_item(OP_ADD, 16'hFFFF, 16'h0000, 32'h0000_0000);
      send_item(OP_ADD, 16'h1234, 16'h0001, 32'd5);
      send_item(OP_ADD, 16'h0002, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
      send_item(OP_TICK, 16'h0000, 16'h0000, 32'd1000004);
      send_item(OP_TICK, 16'h0000, 16'h0000, 32'd1000005);
      for (i = 0; i < DEPTH - 1; i++)
         send_item(OP_ADD, ID_W'(16'h0100 + i), 16'h0000, NOW_W'((DEPTH - i) * 100));
      send_item(OP_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(OP_TICK, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
      wait_quiet();
      write_rate({UPS_W{1'b1}});
      send_item(OP_ADD, 16'h5555, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(OP_TICK, 16'hAAAA, 16'h0000, 32'hFFFF_FFFF);

      // random phases, one rate each
      rates[0] = 24'd1;
      rates[1] = {UPS_W{1'b1}};
      rates[2] = '0;
      rates[3] = UPS_RESET;
      rates[4] = UPS_W'($urandom_range(2, 5000));
      rates[5] = UPS_W'($urandom_range(1, 24'hFF_FFFF));
      for (phase = 0; phase < 6; phase++) begin
         wait_quiet();
         write_rate(rates[phase]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // burst flavor: mostly adds, mixed, or mostly ticks
            case ($urandom_range(0, 2))
               0: add_pct = 90;
               1: add_pct = 50;
               default: add_pct = 20;
            endcase
            burst = $urandom_range(1, 12);
            for (i = 0; i < burst; i++) begin
               if ($urandom_range(1, 100) <= add_pct) add_random();
               else tick_random();
               sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 20));
         end
      end

      // drain and report
      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/stq_pkg.sv
hdl/stq_mem.sv
hdl/stq_cmp.sv
hdl/sleep_timer_queue_unit.sv
dv/sleep_timer_queue_unit_tb.sv
